@@ design/bba_pkg.sv @@
// Package for the bitmap block allocator: operation and status codes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package bba_pkg;

    localparam int ADDR_W    = 32;
    localparam int CFG_W     = 14;
    localparam int WORD_BITS = 32;

    localparam logic [CFG_W-1:0] COUNT_MAX      = 14'h3FFF;
    localparam logic [CFG_W-1:0] TOTAL_RESET    = 14'd8192;
    localparam logic [CFG_W-1:0] RESERVED_RESET = 14'd256;
    localparam logic [CFG_W-1:0] USED_RESET     = 14'd8192;

    localparam logic [0:0] CFG_TOTAL    = 1'b0;
    localparam logic [0:0] CFG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic latch;
        logic word_clr;
        logic word_inc;
        logic wr_fill;
        logic wr_init;
        logic count_init;
        logic rd_scan;
        logic wr_alloc;
        logic rd_free;
        logic wr_free;
        logic set_oom;
        logic set_ignored;
        logic res_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        t_op  op;
        logic last_word;
        logic found;
        logic scan_last;
        logic in_range;
        logic bit_used;
        logic out_free;
    } t_sts;

endpackage

@@ design/bba_req_if.sv @@
// Request channel of the bitmap block allocator: operation and byte address.
// Depends on bba_pkg.
interface bba_req_if
    import bba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink   (input valid, input op, input address, output ready);
endinterface

@@ design/bba_rsp_if.sv @@
// Response channel of the bitmap block allocator: block address, status and free count.
// Depends on bba_pkg.
interface bba_rsp_if
    import bba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_address;
    logic [1:0]        status;
    logic [CFG_W-1:0]  free_blocks;

    modport source (output valid, output block_address, output status, output free_blocks,
                    input ready);
    modport sink   (input valid, input block_address, input status, input free_blocks,
                    output ready);
endinterface

@@ design/bitmap_block_allocator_unit.sv @@
// Top level of the bitmap block allocator: a first-fit page-frame allocator.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ctrl and bba_dp.
//
//   Channel   Direction  Transfer contents
//   i_req     in         op (init/alloc/free/query), byte address for free
//   o_rsp     out        block_address, status, free_blocks (one per request)
//   i_cfg_*   in         register write: index 0 total blocks, 1 reserved blocks
//
// After reset the bitmap memory is filled with ones, one word per cycle; no
// request is taken until that pass ends. A query goes straight to its response,
// a free reads the word of its block and checks its bit (a block out of range
// skips both), an init writes every bitmap word in turn, and an allocate reads
// and checks one word after another until it finds a free bit or reaches the
// last word below the total; a check state follows every registered read.
// A finished response sits in the output register until its transfer, and the
// next request is held off only once a second response is ready and waiting.
//
// The bitmap keeps one bit per block (set means used), packed 32 to a word.
// The used-block count saturates at both ends, so a register change after an
// init cannot wrap it; the free count reports zero whenever the used count is
// above the effective total, which is the total register clipped to the
// map capacity. BLOCK_BYTES is a power of two, so the block index of a byte
// address is a right shift.
module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS  = 8192,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bba_req_if.sink          i_req,
    bba_rsp_if.source        o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller: sequences fill, init sweep, word scan and free check.
    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath: registers, bitmap memory, search logic and output register.
    bba_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );

endmodule

@@ design/bba_ctrl.sv @@
// Controller state machine of the bitmap block allocator.
// Depends on bba_pkg; drives the datapath bba_dp through t_cmd and reads t_sts.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_FILL     = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_INIT     = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CHK = 8'b0001_0000,
        S_FREE_RD  = 8'b0010_0000,
        S_FREE_CHK = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_FILL: begin
                o_cmd.wr_fill = 1'b1;
                if (i_sts.last_word) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.word_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.latch    = 1'b1;
                    o_cmd.word_clr = 1'b1;
                    case (i_sts.op)
                        OP_INIT:  n_state = S_INIT;
                        OP_ALLOC: n_state = S_SCAN_RD;
                        OP_FREE:  n_state = S_FREE_RD;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.wr_init = 1'b1;
                if (i_sts.last_word) begin
                    o_cmd.count_init = 1'b1;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.word_inc = 1'b1;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.found) begin
                    o_cmd.wr_alloc = 1'b1;
                    n_state        = S_RESP;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.word_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_FREE_RD: begin
                if (i_sts.in_range) begin
                    o_cmd.rd_free = 1'b1;
                    n_state       = S_FREE_CHK;
                end else begin
                    o_cmd.set_ignored = 1'b1;
                    n_state           = S_RESP;
                end
            end
            S_FREE_CHK: begin
                if (i_sts.bit_used) begin
                    o_cmd.wr_free = 1'b1;
                end else begin
                    o_cmd.set_ignored = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

endmodule

@@ design/bba_dp.sv @@
// Datapath of the bitmap block allocator: configuration registers, bitmap memory,
// used-block counter, word search logic and the output register.
// Depends on bba_pkg, bba_req_if and bba_rsp_if; commanded by bba_ctrl.
module bba_dp
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS  = 8192,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    bba_req_if.sink          i_req,
    bba_rsp_if.source        o_rsp
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);
    localparam int SHIFT     = $clog2(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] MAX_B = ADDR_W'(MAX_BLOCKS);

    // Bit j is set when block base + j lies below limit.
    function automatic logic [WORD_BITS-1:0] below_mask(logic [ADDR_W-1:0] base,
                                                        logic [ADDR_W-1:0] limit);
        logic [ADDR_W-1:0]    diff;
        logic [WORD_BITS-1:0] m;
        diff = limit - base;
        if (limit <= base) begin
            m = '0;
        end else if (diff >= ADDR_W'(WORD_BITS)) begin
            m = '1;
        end else begin
            m = (WORD_BITS'(1) << diff[4:0]) - WORD_BITS'(1);
        end
        return m;
    endfunction

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [CFG_W-1:0]     r_total;
    logic [CFG_W-1:0]     r_reserved;
    logic [CFG_W-1:0]     r_used;
    logic [WC_W-1:0]      r_word;
    logic [ADDR_W-1:0]    r_addr;
    logic [WORD_BITS-1:0] r_rdata;
    t_status              r_res_status;
    logic [ADDR_W-1:0]    r_res_baddr;
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_baddr;
    t_status              r_out_status;
    logic [CFG_W-1:0]     r_out_free;

    logic [CFG_W-1:0]     w_eff_total;
    logic [ADDR_W-1:0]    w_total32;
    logic [ADDR_W-1:0]    w_base;
    logic [ADDR_W-1:0]    w_blk;
    logic [WW-1:0]        w_free_word;
    logic [WORD_BITS-1:0] w_free_bits;
    logic [WORD_BITS-1:0] w_lowest;
    logic [4:0]           w_pos;
    logic [WORD_BITS-1:0] w_init_word;
    logic [CFG_W-1:0]     w_init_count;
    logic [CFG_W-1:0]     w_free_count;
    logic                 w_out_free;
    logic                 w_wr_en;
    logic [WW-1:0]        w_wr_addr;
    logic [WORD_BITS-1:0] w_wr_data;
    logic                 w_rd_en;
    logic [WW-1:0]        w_rd_addr;

    // A total above the map capacity is clipped to the capacity.
    assign w_eff_total = (ADDR_W'(r_total) > MAX_B) ? MAX_B[CFG_W-1:0] : r_total;
    assign w_total32   = ADDR_W'(w_eff_total);
    assign w_base      = ADDR_W'(r_word) << 5;
    assign w_blk       = r_addr >> SHIFT;
    assign w_free_word = w_blk[5 +: WW];

    // Lowest free bit of the scanned word, ignoring bits at or beyond the total.
    assign w_free_bits = ~r_rdata & below_mask(w_base, w_total32);
    assign w_lowest    = w_free_bits & (~w_free_bits + WORD_BITS'(1));

    always_comb begin
        w_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (w_lowest[j]) begin
                w_pos = w_pos | 5'(j);
            end
        end
    end

    assign w_init_word  = ~below_mask(w_base, w_total32)
                        | below_mask(w_base, ADDR_W'(r_reserved));
    assign w_init_count = (r_reserved < w_eff_total) ? r_reserved : w_eff_total;
    assign w_free_count = (r_used <= w_eff_total) ? (w_eff_total - r_used) : '0;
    assign w_out_free   = !r_out_valid || o_rsp.ready;

    // Memory port selection.
    always_comb begin
        w_wr_en   = i_cmd.wr_fill | i_cmd.wr_init | i_cmd.wr_alloc | i_cmd.wr_free;
        w_wr_addr = i_cmd.wr_free ? w_free_word : r_word[WW-1:0];
        w_rd_en   = i_cmd.rd_scan | i_cmd.rd_free;
        w_rd_addr = i_cmd.rd_free ? w_free_word : r_word[WW-1:0];
        if (i_cmd.wr_fill) begin
            w_wr_data = '1;
        end else if (i_cmd.wr_init) begin
            w_wr_data = w_init_word;
        end else if (i_cmd.wr_alloc) begin
            w_wr_data = r_rdata | w_lowest;
        end else begin
            w_wr_data = r_rdata & ~(WORD_BITS'(1) << w_blk[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // Configuration registers, used count and word counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RESET;
            r_reserved <= RESERVED_RESET;
            r_used     <= USED_RESET;
            r_word     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOTAL:    r_total    <= i_cfg_data;
                    CFG_RESERVED: r_reserved <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_cmd.count_init) begin
                r_used <= w_init_count;
            end else if (i_cmd.wr_alloc && r_used != COUNT_MAX) begin
                r_used <= r_used + 1'b1;
            end else if (i_cmd.wr_free && r_used != '0) begin
                r_used <= r_used - 1'b1;
            end
            if (i_cmd.word_clr) begin
                r_word <= '0;
            end else if (i_cmd.word_inc) begin
                r_word <= r_word + 1'b1;
            end
        end
    end

    // Item and result holding registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_addr       <= i_req.address;
            r_res_status <= ST_DONE;
            r_res_baddr  <= '0;
        end else if (i_cmd.wr_alloc) begin
            r_res_baddr <= (w_base | ADDR_W'(w_pos)) << SHIFT;
        end else if (i_cmd.set_oom) begin
            r_res_status <= ST_OOM;
        end else if (i_cmd.set_ignored) begin
            r_res_status <= ST_IGNORED;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_baddr  <= r_res_baddr;
            r_out_status <= r_res_status;
            r_out_free   <= w_free_count;
        end
    end

    assign i_req.ready         = i_cmd.in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.block_address = r_out_baddr;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.free_blocks   = r_out_free;

    always_comb begin
        o_sts.in_valid  = i_req.valid;
        o_sts.op        = t_op'(i_req.op);
        o_sts.last_word = (r_word == WC_W'(MAP_WORDS - 1));
        o_sts.found     = |w_free_bits;
        o_sts.scan_last = (w_base + ADDR_W'(WORD_BITS)) >= w_total32;
        o_sts.in_range  = w_blk < w_total32;
        o_sts.bit_used  = r_rdata[w_blk[4:0]];
        o_sts.out_free  = w_out_free;
    end

endmodule

@@ tb/bba_alloc_monitor.sv @@
// Monitor for the bitmap block allocator: watches the register port and both channels,
// keeps its own block map to predict each response, and compares every transfer.
// Depends on bba_pkg, bba_req_if and bba_rsp_if.
module bba_alloc_monitor
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS  = 8192,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bba_req_if               req_mon,
    bba_rsp_if               rsp_mon,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        t_status           status;
        logic [CFG_W-1:0]  free_blocks;
    } t_alloc_result;

    bit               block_used [MAX_BLOCKS];
    logic [CFG_W-1:0] used_blocks;
    logic [CFG_W-1:0] total_reg;
    logic [CFG_W-1:0] reserved_reg;
    t_alloc_result    outstanding_results [$];

    // The total register is clipped to the map capacity wherever it is used.
    function automatic int unsigned effective_total();
        return (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : total_reg;
    endfunction

    // Applies one request to the block map and returns the response it should give.
    function automatic t_alloc_result update_block_map(t_op op, logic [ADDR_W-1:0] address);
        t_alloc_result res;
        int unsigned   limit;
        logic [63:0]   blk;
        logic [63:0]   byte_addr;
        limit             = effective_total();
        res.block_address = '0;
        res.status        = ST_DONE;
        case (op)
            OP_INIT: begin
                for (int b = 0; b < MAX_BLOCKS; b++) begin
                    block_used[b] = (b < reserved_reg) || (b >= limit);
                end
                used_blocks = (reserved_reg < limit) ? reserved_reg : CFG_W'(limit);
            end
            OP_ALLOC: begin
                res.status = ST_OOM;
                for (int b = 0; b < limit; b++) begin
                    if (!block_used[b]) begin
                        block_used[b] = 1'b1;
                        if (used_blocks != COUNT_MAX) used_blocks++;
                        byte_addr         = 64'(b) * BLOCK_BYTES;
                        res.block_address = byte_addr[ADDR_W-1:0];
                        res.status        = ST_DONE;
                        break;
                    end
                end
            end
            OP_FREE: begin
                blk = 64'(address) / BLOCK_BYTES;
                if (blk < limit && block_used[blk]) begin
                    block_used[blk] = 1'b0;
                    if (used_blocks != '0) used_blocks--;
                end else begin
                    res.status = ST_IGNORED;
                end
            end
            default: begin
            end
        endcase
        res.free_blocks = (used_blocks <= limit) ? CFG_W'(limit - used_blocks) : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (!i_rst_n) begin
            foreach (block_used[b]) block_used[b] = 1'b1;
            used_blocks  = USED_RESET;
            total_reg    = TOTAL_RESET;
            reserved_reg = RESERVED_RESET;
            outstanding_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TOTAL) total_reg = i_cfg_data;
                else reserved_reg = i_cfg_data;
            end
            if (req_mon.valid && req_mon.ready) begin
                outstanding_results.push_back(update_block_map(t_op'(req_mon.op),
                                                               req_mon.address));
            end
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (outstanding_results.size() == 0) begin
                    $error("Response transfer with no request waiting: block_address 0x%08h",
                           rsp_mon.block_address);
                    o_fail_count++;
                end else begin
                    exp_res = outstanding_results.pop_front();
                    if (rsp_mon.block_address !== exp_res.block_address) begin
                        $error("block_address: expected 0x%08h, got 0x%08h",
                               exp_res.block_address, rsp_mon.block_address);
                        o_fail_count++;
                    end
                    if (rsp_mon.status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, rsp_mon.status);
                        o_fail_count++;
                    end
                    if (rsp_mon.free_blocks !== exp_res.free_blocks) begin
                        $error("free_blocks: expected %0d, got %0d",
                               exp_res.free_blocks, rsp_mon.free_blocks);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = outstanding_results.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the bitmap block allocator testbench: clock, reset, register writes and request
// stimulus, a randomly stalling response sink, and the final verdict.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bitmap_block_allocator_unit and bba_alloc_monitor.
module testbench;
    import bba_pkg::*;

    localparam int MAX_BLOCKS  = 8192;
    localparam int BLOCK_BYTES = 4096;

    // Pause after the last response before a register write, and the drain at the end.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;

    // Slowest correct run: about 2000 requests, each an out-of-memory scan of every map
    // word plus the longest gap on both sides, and the clearing pass after reset. This
    // bound is several times that.
    localparam longint TIMEOUT_UNITS = 64'd50_000_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [0:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    int pending;
    int fail_count;

    // Stimulus bookkeeping. The stimulus only knows what it has sent, never what the
    // block answered, so frees are aimed at blocks that are likely to be in use.
    int unsigned cur_total;
    int unsigned cur_reserved;
    int unsigned allocs_since_init;
    int unsigned op_count [4];
    int unsigned settings_used;
    int unsigned hold_offs;
    bit          idle_off;

    bitmap_block_allocator_unit #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    bba_alloc_monitor #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_alloc_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both sides draw their wait from here. While idle_off is set neither side waits, so
    // the run also contains stretches of back-to-back transfers.
    function automatic int unsigned draw_wait();
        return idle_off ? 0 : $urandom_range(0, 14);
    endfunction

    // Picks the byte address for a free. Most land on blocks that the current setting can
    // hold, near the boundary or just above the reserved region where allocations go; the
    // rest are arbitrary 32-bit addresses, so that the high bits are exercised and most of
    // those fall out of range. The other addresses get a random offset within the block.
    function automatic logic [ADDR_W-1:0] free_address();
        int unsigned sel;
        int unsigned eff;
        int unsigned lo;
        int unsigned blk;
        logic [63:0] byte_addr;
        sel = $urandom_range(0, 9);
        eff = (cur_total > MAX_BLOCKS) ? MAX_BLOCKS : cur_total;
        lo  = (cur_reserved < eff) ? cur_reserved : eff;
        if (sel < 2) return $urandom;
        if (sel == 2) blk = (eff == 0) ? 0 : eff - 1 + $urandom_range(0, 1);
        else if (sel < 5) blk = (eff == 0) ? 0 : $urandom_range(0, eff - 1);
        else blk = $urandom_range(lo, lo + allocs_since_init + 3);
        byte_addr = 64'(blk) * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
        return byte_addr[ADDR_W-1:0];
    endfunction

    // Presents one request and returns at the falling edge after its transfer. Valid is
    // left high, so a request that follows with no gap is simply presented over it.
    task automatic send(input t_op op, input logic [ADDR_W-1:0] address);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.address <= address;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        op_count[op]++;
        if (op == OP_INIT) allocs_since_init = 0;
        else if (op == OP_ALLOC) allocs_since_init++;
    endtask

    // Stops sending until every response has come back.
    task automatic hold_until_idle();
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        hold_offs++;
    endtask

    // Registers are only written with the block idle: every response returned and a
    // short settle after the last transfer.
    task automatic program_regs(input int unsigned total, input int unsigned reserved);
        hold_until_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TOTAL;
        i_cfg_data <= CFG_W'(total);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RESERVED;
        i_cfg_data <= CFG_W'(reserved);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_total    = total;
        cur_reserved = reserved;
        settings_used++;
    endtask

    // One random request: mostly allocations and frees, with queries and the odd re-init.
    // The address field of non-free requests is random too, since the block ignores it.
    task automatic random_item();
        int unsigned pick;
        if ($urandom_range(0, 39) == 0) idle_off = !idle_off;
        if ($urandom_range(0, 299) == 0) hold_until_idle();
        pick = $urandom_range(0, 99);
        if (pick < 2) send(OP_INIT, $urandom);
        else if (pick < 50) send(OP_ALLOC, $urandom);
        else if (pick < 85) send(OP_FREE, free_address());
        else send(OP_QUERY, $urandom);
    endtask

    task automatic run_setting(input int unsigned total, input int unsigned reserved,
                               input bit with_init, input int unsigned items);
        program_regs(total, reserved);
        if (with_init) send(OP_INIT, $urandom);
        for (int unsigned n = 0; n < items; n++) random_item();
    endtask

    // Response sink: waits a random number of cycles, then holds ready high until a
    // transfer takes place.
    initial begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned rand_total;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_TOTAL;
        i_cfg_data     = '0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_QUERY;
        req_ch.address = '0;
        cur_total         = TOTAL_RESET;
        cur_reserved      = RESERVED_RESET;
        allocs_since_init = 0;
        settings_used     = 1;
        hold_offs         = 0;
        idle_off          = 1'b0;
        foreach (op_count[k]) op_count[k] = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, on the reset register values. Out of reset every block is marked
        // used, so an allocation runs out of memory until something is freed or the map
        // is initialised.
        send(OP_QUERY, '0);
        send(OP_ALLOC, '0);
        send(OP_FREE, 32'h0000_0000);          // block 0 is used after reset, so it frees
        send(OP_ALLOC, 32'hFFFF_FFFF);         // and is handed straight back
        send(OP_FREE, 32'hFFFF_FFFF);          // highest address, far out of range
        send(OP_INIT, '0);
        send(OP_ALLOC, '0);                    // first block above the reserved region
        send(OP_ALLOC, '0);
        send(OP_FREE, 32'h0010_0FFF);          // last byte of that first block
        send(OP_FREE, 32'h0010_0000);          // same block again: already free
        send(OP_ALLOC, '0);                    // first fit takes it again
        send(OP_FREE, 32'h0000_1000);          // a reserved block is used, so it frees
        send(OP_ALLOC, '0);                    // and now it is the lowest free one
        send(OP_FREE, 32'h01FF_F000);          // top block in range, still free
        send(OP_FREE, 32'h0200_0000);          // first block past the total
        send(OP_QUERY, 32'hFFFF_FFFF);

        // Let everything come back before going on.
        hold_until_idle();

        // Random part, one register setting after another.
        run_setting(8192, 256, 1'b1, 350);     // reset values written back explicitly
        run_setting(0, 0, 1'b1, 40);           // nothing managed at all
        run_setting(16383, 0, 1'b1, 300);      // total above capacity, clipped to the map
        run_setting(64, 100, 1'b1, 80);        // reserve above the total
        run_setting(64, 0, 1'b1, 250);         // small map that fills up and runs out
        run_setting(40, 8, 1'b1, 150);
        // No init here: the used count no longer matches the map and saturates at zero
        // as the blocks above the old total, still marked used, are freed.
        run_setting(8192, 16383, 1'b0, 150);
        run_setting(100, 16383, 1'b1, 50);     // largest reserve
        rand_total = $urandom_range(1, 400);
        run_setting(rand_total, $urandom_range(0, rand_total), 1'b1, 300);
        run_setting(8192, 0, 1'b1, 350);       // no reserve, allocations from block 0

        req_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d init, %0d allocate, %0d free, %0d query.",
                 op_count[OP_INIT] + op_count[OP_ALLOC] + op_count[OP_FREE]
                 + op_count[OP_QUERY], op_count[OP_INIT], op_count[OP_ALLOC],
                 op_count[OP_FREE], op_count[OP_QUERY]);
        $display("Register settings used: %0d; sender held until idle %0d times.",
                 settings_used, hold_offs);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("Timed out with %0d responses still awaited.", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
design/bba_pkg.sv
design/bba_req_if.sv
design/bba_rsp_if.sv
design/bba_ctrl.sv
design/bba_dp.sv
design/bitmap_block_allocator_unit.sv
tb/bba_alloc_monitor.sv
tb/testbench.sv
